>>> rtl/core/source_token_lexer_defines.svh
// ----------------------------------------------------------------------------
// Source token lexer assertion macros
// Shared macros for the concurrent checks on the lexer ports.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_LEXER_DEFINES_SVH
`define SOURCE_TOKEN_LEXER_DEFINES_SVH

// Check that is evaluated at every rising clock edge, reset included.
`define SLT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Check that is switched off while the active-low reset is asserted.
`define SLT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// Source token lexer package
// Field widths, token kinds, error codes, character classes and the
// token record shared by the lexer modules.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Field widths of one token.
    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;
    localparam int KIND_BITS   = 6;
    localparam int ERR_BITS    = 2;

    // Output queue sizing.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Token kinds.
    localparam logic [KIND_BITS-1:0] KIND_END        = 6'd0;
    localparam logic [KIND_BITS-1:0] KIND_IDENT      = 6'd1;
    localparam logic [KIND_BITS-1:0] KIND_INT        = 6'd2;
    localparam logic [KIND_BITS-1:0] KIND_FLOAT      = 6'd3;
    localparam logic [KIND_BITS-1:0] KIND_STRING     = 6'd4;
    localparam logic [KIND_BITS-1:0] KIND_REMARK     = 6'd5;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN     = 6'd6;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN     = 6'd7;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 6'd8;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 6'd9;
    localparam logic [KIND_BITS-1:0] KIND_LBRACKET   = 6'd10;
    localparam logic [KIND_BITS-1:0] KIND_RBRACKET   = 6'd11;
    localparam logic [KIND_BITS-1:0] KIND_SEP_COLON  = 6'd12;
    localparam logic [KIND_BITS-1:0] KIND_SEMI       = 6'd13;
    localparam logic [KIND_BITS-1:0] KIND_SEP_COMMA  = 6'd14;
    localparam logic [KIND_BITS-1:0] KIND_PERIOD     = 6'd15;
    localparam logic [KIND_BITS-1:0] KIND_AT         = 6'd16;
    localparam logic [KIND_BITS-1:0] KIND_BANG       = 6'd17;
    localparam logic [KIND_BITS-1:0] KIND_LT         = 6'd18;
    localparam logic [KIND_BITS-1:0] KIND_LE         = 6'd19;
    localparam logic [KIND_BITS-1:0] KIND_GT         = 6'd20;
    localparam logic [KIND_BITS-1:0] KIND_GE         = 6'd21;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN     = 6'd22;
    localparam logic [KIND_BITS-1:0] KIND_EQ         = 6'd23;
    localparam logic [KIND_BITS-1:0] KIND_ADD        = 6'd24;
    localparam logic [KIND_BITS-1:0] KIND_ADD_EQ     = 6'd25;
    localparam logic [KIND_BITS-1:0] KIND_ADD_ADD    = 6'd26;
    localparam logic [KIND_BITS-1:0] KIND_SUB        = 6'd27;
    localparam logic [KIND_BITS-1:0] KIND_SUB_EQ     = 6'd28;
    localparam logic [KIND_BITS-1:0] KIND_SUB_SUB    = 6'd29;
    localparam logic [KIND_BITS-1:0] KIND_MUL        = 6'd30;
    localparam logic [KIND_BITS-1:0] KIND_MUL_EQ     = 6'd31;
    localparam logic [KIND_BITS-1:0] KIND_SLASH      = 6'd32;
    localparam logic [KIND_BITS-1:0] KIND_SLASH_EQ   = 6'd33;
    localparam logic [KIND_BITS-1:0] KIND_PERCENT    = 6'd34;
    localparam logic [KIND_BITS-1:0] KIND_PERCENT_EQ = 6'd35;
    localparam logic [KIND_BITS-1:0] KIND_OR_OR      = 6'd36;
    localparam logic [KIND_BITS-1:0] KIND_AND_AND    = 6'd37;
    localparam logic [KIND_BITS-1:0] KIND_ILLEGAL    = 6'd38;

    // Error codes.
    localparam logic [ERR_BITS-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_INT   = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_FLOAT = 2'd2;
    localparam logic [ERR_BITS-1:0] ERR_CHAR  = 2'd3;

    // Number radix codes.
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // Characters with a special role.
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_VT         = 8'h0B;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;

    // One token as it leaves the block.
    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] end_offset;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [ERR_BITS-1:0]    error_code;
        logic                   last_of_run;
    } t_token;

    // Up to two tokens written to the output queue in one cycle.
    typedef struct packed {
        logic   first_vld;
        logic   second_vld;
        t_token first;
        t_token second;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NEWLINE) || (c == CH_TAB) ||
               (c == CH_CR) || (c == CH_VT);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // True when c is a digit of the given radix.
    function automatic logic radix_digit(input logic [7:0] c, input logic [1:0] radix);
        logic ok;
        case (radix)
            RADIX_BIN: ok = (c == "0") || (c == "1");
            RADIX_OCT: ok = (c >= "0") && (c <= "7");
            RADIX_DEC: ok = is_digit(c);
            default:   ok = is_digit(c) || ((c >= "a") && (c <= "f")) ||
                            ((c >= "A") && (c <= "F"));
        endcase
        return ok;
    endfunction

    // Kind of a character that is a token by itself, KIND_END if none.
    function automatic logic [KIND_BITS-1:0] single_char_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            ":":     k = KIND_SEP_COLON;
            ";":     k = KIND_SEMI;
            ",":     k = KIND_SEP_COMMA;
            ".":     k = KIND_PERIOD;
            "@":     k = KIND_AT;
            "!":     k = KIND_BANG;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

    // Kind of an operator character left alone, KIND_END if c is no operator.
    function automatic logic [KIND_BITS-1:0] lone_op_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            "<":      k = KIND_LT;
            ">":      k = KIND_GT;
            "=":      k = KIND_ASSIGN;
            "+":      k = KIND_ADD;
            "-":      k = KIND_SUB;
            "*":      k = KIND_MUL;
            "/":      k = KIND_SLASH;
            "%":      k = KIND_PERCENT;
            "|", "&": k = KIND_ILLEGAL;
            default:  k = KIND_END;
        endcase
        return k;
    endfunction

    // Kind of an operator character followed by an equals sign.
    function automatic logic [KIND_BITS-1:0] eq_op_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            "<":     k = KIND_LE;
            ">":     k = KIND_GE;
            "=":     k = KIND_EQ;
            "+":     k = KIND_ADD_EQ;
            "-":     k = KIND_SUB_EQ;
            "*":     k = KIND_MUL_EQ;
            "/":     k = KIND_SLASH_EQ;
            "%":     k = KIND_PERCENT_EQ;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/core/slt_ifs.sv
// ----------------------------------------------------------------------------
// Source token lexer channels
// Valid/ready channels for source bytes in and tokens out.
// ----------------------------------------------------------------------------

// Source byte channel.
interface slt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

// Token channel.
interface slt_token_if;
    logic                           valid;
    logic                           ready;
    logic [slt_pkg::KIND_BITS-1:0]   token_kind;
    logic [slt_pkg::OFFSET_BITS-1:0] start_offset;
    logic [slt_pkg::OFFSET_BITS-1:0] end_offset;
    logic [slt_pkg::LINE_BITS-1:0]   start_line;
    logic [slt_pkg::COLUMN_BITS-1:0] start_column;
    logic [slt_pkg::ERR_BITS-1:0]    error_code;
    logic                           last_of_run;

    modport source (
        output valid, output token_kind, output start_offset, output end_offset,
        output start_line, output start_column, output error_code, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input token_kind, input start_offset, input end_offset,
        input start_line, input start_column, input error_code, input last_of_run,
        output ready
    );
endinterface

>>> rtl/core/slt_scan.sv
// ----------------------------------------------------------------------------
// Source token lexer scanner
// Mode machine and position counters. Each accepted item updates the
// state and yields up to two finished tokens for the output queue.
// ----------------------------------------------------------------------------
module slt_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char_byte,
    input  logic           i_end_of_input,
    output slt_pkg::t_push o_push
);
    import slt_pkg::*;

    // Scan modes.
    localparam logic [3:0] MODE_IDLE          = 4'd0;
    localparam logic [3:0] MODE_IDENT         = 4'd1;
    localparam logic [3:0] MODE_NUM_ZERO      = 4'd2;
    localparam logic [3:0] MODE_NUM_RADIX     = 4'd3;
    localparam logic [3:0] MODE_NUM_INT       = 4'd4;
    localparam logic [3:0] MODE_NUM_FRAC      = 4'd5;
    localparam logic [3:0] MODE_NUM_EXP_START = 4'd6;
    localparam logic [3:0] MODE_NUM_EXP       = 4'd7;
    localparam logic [3:0] MODE_STRING        = 4'd8;
    localparam logic [3:0] MODE_STRING_ESC    = 4'd9;
    localparam logic [3:0] MODE_COMMENT       = 4'd10;
    localparam logic [3:0] MODE_OP            = 4'd11;

    typedef struct packed {
        logic                 vld;
        logic [KIND_BITS-1:0] kind;
        logic [ERR_BITS-1:0]  err;
    } t_close;

    // Token that the pending mode turns into when something ends it.
    function automatic t_close close_info(
        input logic [3:0]          mode,
        input logic                ds,
        input logic [ERR_BITS-1:0] pe,
        input logic [7:0]          op
    );
        t_close r;
        r.vld  = 1'b1;
        r.kind = KIND_END;
        r.err  = ERR_NONE;
        case (mode)
            MODE_IDENT: r.kind = KIND_IDENT;
            MODE_NUM_ZERO, MODE_NUM_INT: begin
                r.kind = KIND_INT;
                r.err  = pe;
            end
            MODE_NUM_RADIX: begin
                r.kind = KIND_INT;
                r.err  = ds ? pe : ERR_INT;
            end
            MODE_NUM_FRAC, MODE_NUM_EXP: begin
                r.kind = KIND_FLOAT;
                r.err  = ds ? pe : ERR_FLOAT;
            end
            MODE_NUM_EXP_START: begin
                r.kind = KIND_FLOAT;
                r.err  = ERR_FLOAT;
            end
            MODE_STRING, MODE_STRING_ESC: r.kind = KIND_STRING;
            MODE_COMMENT: r.kind = KIND_REMARK;
            MODE_OP: begin
                r.kind = lone_op_kind(op);
                if (r.kind == KIND_END) begin
                    r.kind = KIND_ILLEGAL;
                end
                r.err = (r.kind == KIND_ILLEGAL) ? ERR_CHAR : ERR_NONE;
            end
            default: r.vld = 1'b0;
        endcase
        return r;
    endfunction

    logic [3:0]             r_mode, n_mode;
    logic [1:0]             r_radix, n_radix;
    logic                   r_digits, n_digits;
    logic [ERR_BITS-1:0]    r_pend_err, n_pend_err;
    logic [7:0]             r_op, n_op;
    logic [OFFSET_BITS-1:0] r_tok_off, n_tok_off;
    logic [LINE_BITS-1:0]   r_tok_line, n_tok_line;
    logic [COLUMN_BITS-1:0] r_tok_col, n_tok_col;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;

    logic [7:0]             w_c;
    logic [OFFSET_BITS-1:0] w_next;
    t_close                 w_close;
    logic                   w_a_vld;
    logic [KIND_BITS-1:0]   w_a_kind;
    logic [ERR_BITS-1:0]    w_a_err;
    logic                   w_a_at_next;
    logic                   w_b_vld;
    logic [KIND_BITS-1:0]   w_b_kind;
    logic [ERR_BITS-1:0]    w_b_err;
    logic                   w_do_idle;
    t_token                 w_tok_a;
    t_token                 w_tok_b;

    assign w_c     = i_char_byte;
    assign w_next  = r_off + OFFSET_BITS'(1);
    assign w_close = close_info(r_mode, r_digits, r_pend_err, r_op);

    // Next state and the tokens that this item finishes. Token A is the
    // pending token (start from the token registers); token B starts at
    // the current position.
    always_comb begin
        n_mode      = r_mode;
        n_radix     = r_radix;
        n_digits    = r_digits;
        n_pend_err  = r_pend_err;
        n_op        = r_op;
        n_tok_off   = r_tok_off;
        n_tok_line  = r_tok_line;
        n_tok_col   = r_tok_col;
        n_off       = r_off;
        n_line      = r_line;
        n_col       = r_col;
        w_a_vld     = 1'b0;
        w_a_kind    = KIND_END;
        w_a_err     = ERR_NONE;
        w_a_at_next = 1'b0;
        w_b_vld     = 1'b0;
        w_b_kind    = KIND_END;
        w_b_err     = ERR_NONE;
        w_do_idle   = 1'b0;

        if (i_end_of_input) begin
            // Flush the pending token, then the end token at the current place.
            w_a_vld    = w_close.vld;
            w_a_kind   = w_close.kind;
            w_a_err    = w_close.err;
            w_b_vld    = 1'b1;
            w_b_kind   = KIND_END;
            n_mode     = MODE_IDLE;
            n_tok_off  = r_off;
            n_tok_line = r_line;
            n_tok_col  = r_col;
        end else begin
            case (r_mode)
                MODE_IDENT: begin
                    if (!(is_letter(w_c) || is_digit(w_c) || (w_c == CH_UNDERSCORE))) begin
                        w_do_idle = 1'b1;
                    end
                end
                MODE_NUM_ZERO, MODE_NUM_INT: begin
                    if ((r_mode == MODE_NUM_ZERO) && (w_c inside {"b", "B"})) begin
                        n_radix  = RADIX_BIN;
                        n_digits = 1'b0;
                        n_mode   = MODE_NUM_RADIX;
                    end else if ((r_mode == MODE_NUM_ZERO) && (w_c inside {"o", "O"})) begin
                        n_radix  = RADIX_OCT;
                        n_digits = 1'b0;
                        n_mode   = MODE_NUM_RADIX;
                    end else if ((r_mode == MODE_NUM_ZERO) && (w_c inside {"d", "D"})) begin
                        n_radix  = RADIX_DEC;
                        n_digits = 1'b0;
                        n_mode   = MODE_NUM_RADIX;
                    end else if ((r_mode == MODE_NUM_ZERO) && (w_c inside {"x", "X"})) begin
                        n_radix  = RADIX_HEX;
                        n_digits = 1'b0;
                        n_mode   = MODE_NUM_RADIX;
                    end else if (is_digit(w_c)) begin
                        n_mode = MODE_NUM_INT;
                    end else if (w_c == CH_DOT) begin
                        n_mode   = MODE_NUM_FRAC;
                        n_digits = 1'b0;
                    end else if (w_c inside {"e", "E"}) begin
                        n_mode = MODE_NUM_EXP_START;
                    end else begin
                        w_do_idle = 1'b1;
                    end
                end
                MODE_NUM_RADIX: begin
                    if (radix_digit(w_c, r_radix)) begin
                        n_digits = 1'b1;
                    end else begin
                        w_do_idle = 1'b1;
                    end
                end
                MODE_NUM_FRAC: begin
                    if (is_digit(w_c)) begin
                        n_digits = 1'b1;
                    end else if (w_c inside {"e", "E"}) begin
                        if (!r_digits) begin
                            n_pend_err = ERR_FLOAT;
                        end
                        n_mode = MODE_NUM_EXP_START;
                    end else begin
                        w_do_idle = 1'b1;
                    end
                end
                MODE_NUM_EXP_START: begin
                    // An optional sign, else the byte is looked at as an exponent digit.
                    n_digits = 1'b0;
                    n_mode   = MODE_NUM_EXP;
                    if (w_c inside {"+", "-"}) begin
                        n_digits = 1'b0;
                    end else if (is_digit(w_c)) begin
                        n_digits = 1'b1;
                    end else begin
                        w_do_idle = 1'b1;
                    end
                end
                MODE_NUM_EXP: begin
                    if (is_digit(w_c)) begin
                        n_digits = 1'b1;
                    end else begin
                        w_do_idle = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (w_c == CH_QUOTE) begin
                        w_a_vld     = 1'b1;
                        w_a_kind    = KIND_STRING;
                        w_a_at_next = 1'b1;
                        n_mode      = MODE_IDLE;
                    end else if (w_c == CH_BACKSLASH) begin
                        n_mode = MODE_STRING_ESC;
                    end
                end
                MODE_STRING_ESC: begin
                    n_mode = MODE_STRING;
                end
                MODE_COMMENT: begin
                    if (w_c == CH_NEWLINE) begin
                        w_do_idle = 1'b1;
                    end
                end
                MODE_OP: begin
                    if ((w_c == "=") && !(r_op inside {"|", "&"})) begin
                        w_a_vld     = 1'b1;
                        w_a_kind    = eq_op_kind(r_op);
                        w_a_at_next = 1'b1;
                        n_mode      = MODE_IDLE;
                    end else if ((w_c == r_op) && (r_op inside {"+", "-", "|", "&"})) begin
                        w_a_vld     = 1'b1;
                        w_a_at_next = 1'b1;
                        n_mode      = MODE_IDLE;
                        case (r_op)
                            "+":     w_a_kind = KIND_ADD_ADD;
                            "-":     w_a_kind = KIND_SUB_SUB;
                            "|":     w_a_kind = KIND_OR_OR;
                            default: w_a_kind = KIND_AND_AND;
                        endcase
                    end else if ((w_c == r_op) && (r_op == CH_SLASH)) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        w_do_idle = 1'b1;
                    end
                end
                default: begin
                    w_do_idle = 1'b1;
                end
            endcase

            // A byte that ends a pending token closes it, then starts afresh.
            if (w_do_idle) begin
                w_a_vld  = w_close.vld;
                w_a_kind = w_close.kind;
                w_a_err  = w_close.err;
                n_mode   = MODE_IDLE;
                if (!is_space(w_c)) begin
                    n_tok_off  = r_off;
                    n_tok_line = r_line;
                    n_tok_col  = r_col;
                    n_pend_err = ERR_NONE;
                    n_digits   = 1'b0;
                    if (is_letter(w_c)) begin
                        n_mode = MODE_IDENT;
                    end else if (w_c == CH_ZERO) begin
                        n_mode = MODE_NUM_ZERO;
                    end else if (is_digit(w_c)) begin
                        n_mode = MODE_NUM_INT;
                    end else if (w_c == CH_QUOTE) begin
                        n_mode = MODE_STRING;
                    end else if (single_char_kind(w_c) != KIND_END) begin
                        w_b_vld  = 1'b1;
                        w_b_kind = single_char_kind(w_c);
                    end else if (lone_op_kind(w_c) != KIND_END) begin
                        n_op   = w_c;
                        n_mode = MODE_OP;
                    end else begin
                        w_b_vld  = 1'b1;
                        w_b_kind = KIND_ILLEGAL;
                        w_b_err  = ERR_CHAR;
                    end
                end
            end

            // Position counters: offset wraps, line and column saturate.
            n_off = w_next;
            if (w_c == CH_NEWLINE) begin
                n_col = COLUMN_BITS'(1);
                if (r_line != {LINE_BITS{1'b1}}) begin
                    n_line = r_line + LINE_BITS'(1);
                end
            end else if (r_col != {COLUMN_BITS{1'b1}}) begin
                n_col = r_col + COLUMN_BITS'(1);
            end
        end
    end

    // Assemble the two candidate tokens.
    always_comb begin
        w_tok_a.kind         = w_a_kind;
        w_tok_a.start_offset = r_tok_off;
        w_tok_a.end_offset   = w_a_at_next ? w_next : r_off;
        w_tok_a.start_line   = r_tok_line;
        w_tok_a.start_column = r_tok_col;
        w_tok_a.error_code   = w_a_err;
        w_tok_a.last_of_run  = !w_b_vld;

        w_tok_b.kind         = w_b_kind;
        w_tok_b.start_offset = r_off;
        w_tok_b.end_offset   = i_end_of_input ? r_off : w_next;
        w_tok_b.start_line   = r_line;
        w_tok_b.start_column = r_col;
        w_tok_b.error_code   = w_b_err;
        w_tok_b.last_of_run  = 1'b1;
    end

    // Tokens are packed to the front: A if present, then B.
    assign o_push.first_vld  = i_accept && (w_a_vld || w_b_vld);
    assign o_push.second_vld = i_accept && w_a_vld && w_b_vld;
    assign o_push.first      = w_a_vld ? w_tok_a : w_tok_b;
    assign o_push.second     = w_tok_b;

    // State registers, updated once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_radix    <= RADIX_BIN;
            r_digits   <= 1'b0;
            r_pend_err <= ERR_NONE;
            r_op       <= '0;
            r_tok_off  <= '0;
            r_tok_line <= '0;
            r_tok_col  <= '0;
            r_off      <= '0;
            r_line     <= LINE_BITS'(1);
            r_col      <= COLUMN_BITS'(1);
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_radix    <= n_radix;
            r_digits   <= n_digits;
            r_pend_err <= n_pend_err;
            r_op       <= n_op;
            r_tok_off  <= n_tok_off;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_off      <= n_off;
            r_line     <= n_line;
            r_col      <= n_col;
        end
    end

endmodule

>>> rtl/core/slt_ofifo.sv
// ----------------------------------------------------------------------------
// Source token lexer output queue
// Small queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
module slt_ofifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  slt_pkg::t_push i_push,
    output logic           o_ready,
    slt_token_if.source    o_token
);
    import slt_pkg::*;

    localparam logic [FIFO_CNT_BITS-1:0] READY_LIMIT = FIFO_CNT_BITS'(FIFO_DEPTH - 2);

    t_token                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp, n_wp;
    logic [FIFO_PTR_BITS-1:0] r_rp, n_rp;
    logic [FIFO_CNT_BITS-1:0] r_count, n_count;
    logic [1:0]               w_push_n;
    logic                     w_pop;
    t_token                   w_head;

    assign w_push_n = {1'b0, i_push.first_vld} + {1'b0, i_push.second_vld};
    assign w_pop    = o_token.valid && o_token.ready;

    // Room for two more tokens is needed before the next item is taken.
    assign o_ready = (r_count <= READY_LIMIT);

    assign n_wp    = r_wp + FIFO_PTR_BITS'(w_push_n);
    assign n_rp    = r_rp + FIFO_PTR_BITS'(w_pop);
    assign n_count = r_count + FIFO_CNT_BITS'(w_push_n) - FIFO_CNT_BITS'(w_pop);

    // Token storage.
    always_ff @(posedge i_clk) begin
        if (i_push.first_vld) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.second_vld) begin
            r_mem[r_wp + FIFO_PTR_BITS'(1)] <= i_push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Head of the queue drives the token channel.
    assign w_head               = r_mem[r_rp];
    assign o_token.valid        = (r_count != '0);
    assign o_token.token_kind   = w_head.kind;
    assign o_token.start_offset = w_head.start_offset;
    assign o_token.end_offset   = w_head.end_offset;
    assign o_token.start_line   = w_head.start_line;
    assign o_token.start_column = w_head.start_column;
    assign o_token.error_code   = w_head.error_code;
    assign o_token.last_of_run  = w_head.last_of_run;

endmodule

>>> rtl/core/source_token_lexer.sv
// ----------------------------------------------------------------------------
// Source token lexer
// Streaming lexer: ASCII bytes in, tokens with position and error out.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per clock and returns tokens (kind, byte
// range, line, column, error code) on a separate channel. A byte updates a
// small mode machine in the same cycle it is accepted; the tokens it finishes,
// at most two per item, are written into a four-entry token queue whose head
// drives the output. Input ready stays high while the queue holds two
// tokens or fewer, so the block runs at one item per clock as long as the
// token consumer keeps pace; it stalls only when the consumer falls behind.
// An item with end_of_input set flushes any pending token and then emits the
// end token. last_of_run marks the final token of each item.
// ----------------------------------------------------------------------------
module source_token_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slt_byte_if.sink   i_byte,
    slt_token_if.source o_token
);
    import slt_pkg::*;

    logic  w_ready;
    logic  w_accept;
    t_push w_push;

    // Input handshake.
    assign i_byte.ready = w_ready;
    assign w_accept     = i_byte.valid && w_ready;

    // Mode machine and position counters.
    slt_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_char_byte    (i_byte.char_byte),
        .i_end_of_input (i_byte.end_of_input),
        .o_push         (w_push)
    );

    // Token queue towards the consumer.
    slt_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_ready),
        .o_token (o_token)
    );

endmodule

>>> rtl/core/slt_checker.sv
// ----------------------------------------------------------------------------
// Source token lexer port checker
// Concurrent checks on the lexer ports, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_eoi,
    input logic                           i_out_valid,
    input logic [slt_pkg::KIND_BITS-1:0]   i_kind,
    input logic [slt_pkg::OFFSET_BITS-1:0] i_start,
    input logic [slt_pkg::OFFSET_BITS-1:0] i_end,
    input logic [slt_pkg::ERR_BITS-1:0]    i_err,
    input logic                           i_last
);
    import slt_pkg::*;

`include "source_token_lexer_defines.svh"

    // Reset empties the token queue.
    `SLT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "token out after reset")

    // Input is held off only while tokens are waiting.
    `SLT_ASSERT(a_stall_backlog, i_clk, i_rst_n, !i_in_ready |-> i_out_valid, "stall without backlog")

    // An end-of-input item taken while no token is waiting yields a token.
    `SLT_ASSERT(a_eoi_token, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_eoi && !i_out_valid |=> i_out_valid, "end item lost")

    // The end token is empty, error free and closes its run.
    `SLT_ASSERT(a_end_shape, i_clk, i_rst_n, i_out_valid && (i_kind == KIND_END) |-> (i_start == i_end) && (i_err == ERR_NONE) && i_last, "bad end token")

    // Illegal character kind and error code go together.
    `SLT_ASSERT(a_illegal_err, i_clk, i_rst_n, i_out_valid |-> ((i_kind == KIND_ILLEGAL) == (i_err == ERR_CHAR)), "illegal kind and error disagree")

endmodule

bind source_token_lexer slt_checker u_slt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_in_eoi    (i_byte.end_of_input),
    .i_out_valid (o_token.valid),
    .i_kind      (o_token.token_kind),
    .i_start     (o_token.start_offset),
    .i_end       (o_token.end_offset),
    .i_err       (o_token.error_code),
    .i_last      (o_token.last_of_run)
);
